@@ rtl/lvr_pkg.sv @@
// ---------------------------------------------------------------------------
// lvr_pkg
// Shared types, constants and elaboration-time functions of the log volume
// ramp: controller/datapath command and status bundles, exponent constants.
// ---------------------------------------------------------------------------
package lvr_pkg;

	localparam logic [15:0] SCALE_DEFAULT = 16'd1163;
	localparam int          LOG2_TEN_Q16  = 217706;   // log2(10) in Q16
	localparam logic [23:0] GAIN_MAX      = 24'hFFFFFF;
	localparam int          EXP_BITS      = 16;       // fraction bits of the octave exponent
	localparam int          KW            = $clog2(EXP_BITS);
	localparam int          MANT_FRAC     = 30;       // mantissa is Q30

	// controller -> datapath
	typedef struct packed {
		logic load_in;    // tick accepted: step tracked setting
		logic do_mul1;    // delta * scale
		logic do_mul2;    // * log2(10), seed mantissa
		logic do_iter;    // one mantissa root step
		logic do_final;   // shift, round, saturate into gain register
		logic load_out;   // copy result into output register
	} lvr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic moved;      // incoming target differs from tracked setting
		logic iter_last;  // last mantissa step in progress
	} lvr_stat_t;

	// integer square root, bit-by-bit scheme
	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v   = v_in;
		res = 64'd0;
		b   = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > v) begin
				b = b >> 2;
			end
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 64'd0) begin
				if (v >= res + b) begin
					v   = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
		end
		return res;
	endfunction

	// 2^(2^-(k+1)) in Q30, k = 0 for the top exponent fraction bit
	function automatic logic [30:0] root_q30(input int k);
		logic [63:0] r;
		r = isqrt64(64'd1 << 61);
		for (int j = 1; j < EXP_BITS; j++) begin
			if (j <= k) begin
				r = isqrt64(r << 30);
			end
		end
		return r[30:0];
	endfunction

	// 1.0 at the given number of fraction bits, clipped to the 24-bit field
	function automatic logic [23:0] unity_gain(input int frac_bits);
		logic [24:0] u;
		u = 25'd1 << frac_bits;
		return (u > {1'b0, GAIN_MAX}) ? GAIN_MAX : u[23:0];
	endfunction

endpackage

@@ rtl/lvr_ctrl.sv @@
// ---------------------------------------------------------------------------
// lvr_ctrl
// Sequencer of the volume ramp: accepts a tick, runs the exponent steps
// when the setting moves, and hands the result to the output register.
// ---------------------------------------------------------------------------
module lvr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  lvr_pkg::lvr_stat_t stat,
	output lvr_pkg::lvr_cmd_t  cmd
);
	import lvr_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL1  = 3'd1;
	localparam logic [2:0] S_MUL2  = 3'd2;
	localparam logic [2:0] S_ITER  = 3'd3;
	localparam logic [2:0] S_FINAL = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = stat.moved ? S_MUL1 : S_EMIT;
				end
			end
			S_MUL1: begin
				cmd.do_mul1 = 1'b1;
				state_d     = S_MUL2;
			end
			S_MUL2: begin
				cmd.do_mul2 = 1'b1;
				state_d     = S_ITER;
			end
			S_ITER: begin
				cmd.do_iter = 1'b1;
				if (stat.iter_last) begin
					state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				cmd.do_final = 1'b1;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/lvr_datapath.sv @@
// ---------------------------------------------------------------------------
// lvr_datapath
// Tracked setting, scale register, exponent multipliers, shared mantissa
// multiplier with root table, final shift/round/saturate, output register.
// ---------------------------------------------------------------------------
module lvr_datapath #(
	parameter int GAIN_FRAC_BITS = 16,
	parameter int UNITY_SETTING  = 127
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lvr_pkg::lvr_cmd_t  cmd,
	output lvr_pkg::lvr_stat_t stat,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_data,
	input  logic [7:0]         target_volume,
	output logic [23:0]        gain,
	output logic [7:0]         tracked_volume,
	output logic               gain_changed
);
	import lvr_pkg::*;

	localparam int          SHIFT_OFS  = GAIN_FRAC_BITS - MANT_FRAC;
	localparam logic [23:0] UNITY_GAIN = unity_gain(GAIN_FRAC_BITS);

	logic [7:0]         tracked_q;
	logic [23:0]        gain_q;
	logic               changed_q;
	logic [15:0]        scale_q;
	logic signed [26:0] prod_q;
	logic signed [45:0] y_q;
	logic [31:0]        p_q;
	logic [KW-1:0]      k_q;
	logic [23:0]        gain_o_q;
	logic [7:0]         tracked_o_q;
	logic               changed_o_q;

	logic [30:0]        root_tab [EXP_BITS];
	logic [30:0]        root_sel;
	logic signed [9:0]  delta;
	logic signed [16:0] scale_eff;
	logic [62:0]        mprod;
	logic [62:0]        mround;
	logic [15:0]        frac;
	logic signed [13:0] shift_s;
	logic signed [13:0] shift_r;
	logic [5:0]         sh;
	logic [33:0]        g_rnd;
	logic [33:0]        g_sh;
	logic [23:0]        gain_next;

	for (genvar i = 0; i < EXP_BITS; i++) begin : g_root
		localparam logic [30:0] ROOT = root_q30(i);
		assign root_tab[i] = ROOT;
	end

	assign stat.moved     = (target_volume != tracked_q);
	assign stat.iter_last = (k_q == KW'(EXP_BITS - 1));

	assign delta     = $signed({2'b00, tracked_q}) - $signed(10'(UNITY_SETTING));
	assign scale_eff = $signed({1'b0, (scale_q == 16'd0) ? SCALE_DEFAULT : scale_q});

	// one root step per cycle, top fraction bit first
	assign frac     = y_q[31:16];
	assign root_sel = root_tab[k_q];
	assign mprod    = 63'(p_q) * 63'(root_sel);
	assign mround   = mprod + (63'd1 << (MANT_FRAC - 1));

	// gain = p * 2^(n + frac_bits - 30), n = integer octaves
	assign shift_s = y_q[45:32] + 14'(SHIFT_OFS);
	assign shift_r = -shift_s;
	assign sh      = shift_r[5:0];
	assign g_rnd   = {2'b00, p_q} + (34'd1 << (sh - 6'd1));
	assign g_sh    = g_rnd >> sh;

	always_comb begin
		if (shift_s >= 14'sd0) begin
			gain_next = GAIN_MAX;
		end else if (shift_r >= 14'sd34) begin
			gain_next = 24'd0;    // every bit shifted out
		end else if (g_sh > {10'd0, GAIN_MAX}) begin
			gain_next = GAIN_MAX;
		end else begin
			gain_next = g_sh[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracked_q <= 8'(UNITY_SETTING);
			gain_q    <= UNITY_GAIN;
			changed_q <= 1'b0;
			scale_q   <= SCALE_DEFAULT;
		end else begin
			if (cfg_we) begin
				scale_q <= cfg_data;
			end
			if (cmd.load_in) begin
				changed_q <= stat.moved;
				if (target_volume > tracked_q) begin
					tracked_q <= tracked_q + 8'd1;
				end else if (target_volume < tracked_q) begin
					tracked_q <= tracked_q - 8'd1;
				end
			end
			if (cmd.do_final) begin
				gain_q <= gain_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_mul1) begin
			prod_q <= 27'(delta) * 27'(scale_eff);
		end
		if (cmd.do_mul2) begin
			y_q <= 46'(prod_q) * $signed(46'(LOG2_TEN_Q16));
			p_q <= 32'd1 << MANT_FRAC;
			k_q <= '0;
		end
		if (cmd.do_iter) begin
			if (frac[~k_q]) begin
				p_q <= mround[61:30];
			end
			k_q <= k_q + KW'(1);
		end
		if (cmd.load_out) begin
			gain_o_q    <= gain_q;
			tracked_o_q <= tracked_q;
			changed_o_q <= changed_q;
		end
	end

	assign gain           = gain_o_q;
	assign tracked_volume = tracked_o_q;
	assign gain_changed   = changed_o_q;

endmodule

@@ rtl/log_volume_ramp_core.sv @@
// ---------------------------------------------------------------------------
// log_volume_ramp_core
// Logarithmic volume ramp: one tracked step per sample tick, gain computed
// as a power of ten of the tracked setting, delivered as unsigned fixed point.
// ---------------------------------------------------------------------------
// Each input transaction is one sample tick carrying the requested volume.
// The tracked setting steps by one toward it; when it moves, the gain is
// rebuilt as 10^((tracked - UNITY_SETTING) * step_scale), step_scale in Q0.16
// decades per step (0 selects 1163), and every tick returns one output
// transaction with gain, tracked setting and a changed flag. A tick that
// does not move the setting goes from acceptance straight to the output
// load; a tick that moves it runs two multiply steps for the exponent,
// 16 mantissa steps through one shared 32x31 multiplier and root table (one
// exponent fraction bit per cycle), one shift/round/saturate step and the
// output load. A new tick is accepted as soon as the sequencer is back in
// idle, even while the previous result still waits in the output register.
// step_scale writes are always taken and apply from the next move onward.
// ---------------------------------------------------------------------------
module log_volume_ramp_core #(
	parameter int GAIN_FRAC_BITS = 16,   // fraction bits of gain, 8..24
	parameter int UNITY_SETTING  = 127   // setting with unity gain, 1..254
) (
	input  logic        clk,
	input  logic        arst_n,
	// tick input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  target_volume,
	// result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] gain,
	output logic [7:0]  tracked_volume,
	output logic        gain_changed,
	// step_scale register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] step_scale
);
	import lvr_pkg::*;

	localparam logic [23:0] UNITY_GAIN = unity_gain(GAIN_FRAC_BITS);

	lvr_cmd_t  cmd;
	lvr_stat_t stat;

	// register write never stalls
	assign cfg_ready = 1'b1;

	lvr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lvr_datapath #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS),
		.UNITY_SETTING  (UNITY_SETTING)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_data       (step_scale),
		.target_volume  (target_volume),
		.gain           (gain),
		.tracked_volume (tracked_volume),
		.gain_changed   (gain_changed)
	);

	// an accepted tick leaves the sequencer busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted twice in a row");

	// moving back onto the unity setting must rebuild exactly unity gain
	a_unity_gain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && gain_changed && tracked_volume == 8'(UNITY_SETTING))
		|-> (gain == UNITY_GAIN))
		else $error("gain at unity setting is not unity");

	// only the controller's idle state takes ticks, so no exponent or mantissa step then
	a_no_iter_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(cmd.do_iter || cmd.do_final || cmd.do_mul1 || cmd.do_mul2))
		else $error("datapath command while idle");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for log_volume_ramp_core: random sample ticks with
// ramps toward the volume extremes, bursty sender, stalling receiver, and a
// scoreboard that predicts gain, tracked setting and changed flag per tick.
// ---------------------------------------------------------------------------
module testbench;

	import lvr_pkg::*;

	localparam int GAIN_FRAC      = 16;
	localparam int UNITY          = 127;
	localparam int WATCHDOG_LIMIT = 2000;   // cycles without any transaction
	localparam int PHASE_TICKS    = 270;

	// one predicted output transaction
	typedef struct {
		logic [23:0] gain;
		logic [7:0]  volume;
		logic        changed;
	} gain_result_t;

	// -----------------------------------------------------------------------
	// Scoreboard: own copy of tracked setting, gain register and scale.
	// note_tick() steps the copy and queues the expected result,
	// check_result() compares an output transaction with the oldest one.
	// -----------------------------------------------------------------------
	class volume_scoreboard;
		logic [7:0]        tracked;
		logic [23:0]       gain_reg;
		logic [15:0]       scale;
		longint unsigned   roots [EXP_BITS];   // 2^(2^-(k+1)) in Q30
		gain_result_t      expected_gains [$];
		int                errors;

		function new();
			roots[0] = int_sqrt(64'd1 << 61);
			for (int k = 1; k < EXP_BITS; k++) begin
				roots[k] = int_sqrt(roots[k-1] << 30);
			end
			tracked  = 8'(UNITY);
			gain_reg = (GAIN_FRAC >= 24) ? GAIN_MAX : 24'(1 << GAIN_FRAC);
			scale    = SCALE_DEFAULT;
			errors   = 0;
		endfunction

		// floor square root, one result bit per pass from the top
		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r;
			longint unsigned trial;
			r = 0;
			for (int b = 31; b >= 0; b--) begin
				trial = r | (64'd1 << b);
				if (trial * trial <= v) begin
					r = trial;
				end
			end
			return r;
		endfunction

		// 10^((setting - unity) * scale) as Q(24-frac).frac, saturating
		function logic [23:0] gain_at(logic [7:0] setting);
			longint          delta;
			longint          sc;
			longint          octaves;
			longint          whole;
			longint          shift;
			longint unsigned biased;
			longint unsigned mant;
			longint unsigned rounded;
			logic [15:0]     frac;
			delta   = longint'(setting) - UNITY;
			sc      = (scale == 16'd0) ? longint'(SCALE_DEFAULT) : longint'(scale);
			octaves = delta * sc * LOG2_TEN_Q16;               // Q32 octaves
			biased  = octaves + (longint'(1024) << 32);        // keep floor positive
			whole   = longint'(biased >> 32) - 1024;
			frac    = biased[31:16];
			mant    = 64'd1 << 30;
			for (int k = 0; k < EXP_BITS; k++) begin
				if (frac[EXP_BITS-1-k]) begin
					mant = (mant * roots[k] + (64'd1 << 29)) >> 30;
				end
			end
			shift = whole + GAIN_FRAC - 30;
			if (shift >= 0) begin
				return GAIN_MAX;                                   // overflow
			end
			shift = -shift;
			if (shift >= 63) begin
				return 24'd0;                                      // deep underflow
			end
			rounded = (mant + (64'd1 << (shift - 1))) >> shift;
			return (rounded > longint'(GAIN_MAX)) ? GAIN_MAX : rounded[23:0];
		endfunction

		function void set_scale(logic [15:0] v);
			scale = v;
		endfunction

		function void note_tick(logic [7:0] target);
			gain_result_t r;
			r.changed = (target != tracked);
			if (target > tracked) begin
				tracked = tracked + 8'd1;
			end else if (target < tracked) begin
				tracked = tracked - 8'd1;
			end
			if (r.changed) begin
				gain_reg = gain_at(tracked);
			end
			r.gain   = gain_reg;
			r.volume = tracked;
			expected_gains.push_back(r);
		endfunction

		function int pending();
			return expected_gains.size();
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
			errors++;
		endtask

		task check_result(logic [23:0] g, logic [7:0] v, logic c);
			gain_result_t r;
			if (expected_gains.size() == 0) begin
				report("result without tick", 32'(g), 32'd0);
				return;
			end
			r = expected_gains.pop_front();
			if (g !== r.gain)    report("gain", 32'(g), 32'(r.gain));
			if (v !== r.volume)  report("tracked_volume", 32'(v), 32'(r.volume));
			if (c !== r.changed) report("gain_changed", 32'(c), 32'(r.changed));
		endtask
	endclass

	// -----------------------------------------------------------------------
	// DUT signals; every input starts at a known value
	// -----------------------------------------------------------------------
	logic        clk;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic [7:0]  target_volume  = 8'd0;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic [23:0] gain;
	logic [7:0]  tracked_volume;
	logic        gain_changed;
	logic        cfg_valid      = 1'b0;
	logic        cfg_ready;
	logic [15:0] step_scale     = 16'd0;

	volume_scoreboard sb = new();

	int burst_left  = 0;
	int idle_cycles = 0;

	log_volume_ramp_core #(
		.GAIN_FRAC_BITS (GAIN_FRAC),
		.UNITY_SETTING  (UNITY)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.target_volume  (target_volume),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.gain           (gain),
		.tracked_volume (tracked_volume),
		.gain_changed   (gain_changed),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.step_scale     (step_scale)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// -----------------------------------------------------------------------
	// Monitor. Runs right after each rising edge, so it sees the values the
	// DUT sampled at that edge. The output is checked before the input is
	// noted; a result can never belong to a tick accepted at the same edge.
	// The watchdog lives here too: any transaction clears it.
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				sb.check_result(gain, tracked_volume, gain_changed);
			end
			if (in_valid && in_ready) begin
				sb.note_tick(target_volume);
			end
			if (cfg_valid && cfg_ready) begin
				sb.set_scale(step_scale);
			end
			if ((out_valid && out_ready) || (in_valid && in_ready) ||
			    (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Receiver backpressure: runs of random length in one of four modes
	// (always ready, coin flip, hard stall, alternating).
	// -----------------------------------------------------------------------
	int rx_mode = 0;
	int rx_left = 0;

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(1, 40);
			out_ready <= 1'b1;
		end else begin
			rx_left <= rx_left - 1;
			case (rx_mode)
				0: begin
					out_ready <= 1'b1;
				end
				1: begin
					out_ready <= $urandom_range(0, 1);
				end
				2: begin
					out_ready <= (rx_left > 12);     // stall for the tail of the run
				end
				default: begin
					out_ready <= ~out_ready;
				end
			endcase
		end
	end

	// -----------------------------------------------------------------------
	// Drivers. Each task is entered just after a rising edge and returns just
	// after the edge where its transaction was taken. send_tick leaves valid
	// high so a following tick can go back to back; write_scale drops it.
	// -----------------------------------------------------------------------
	task send_tick(logic [7:0] v);
		in_valid      <= 1'b1;
		target_volume <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// sender in bursts; gaps of varied length so idles land on many
	// phases of the gain computation
	task feed_tick(logic [7:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0
			    : $urandom_range(1, ($urandom_range(0, 3) == 0) ? 25 : 4);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		send_tick(v);
		burst_left--;
	endtask

	// hold off the sender until every expected result has come back
	task drain();
		in_valid   <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_scale(logic [15:0] v);
		cfg_valid  <= 1'b1;
		step_scale <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random phase: mostly ramps (target held so the tracked setting walks
	// far, out to 0 and 255 where gain can underflow or saturate), with some
	// per-tick noise that keeps reversing direction.
	task random_phase(int count);
		int          sent;
		int          len;
		int          pick;
		logic [7:0]  goal;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				len = $urandom_range(1, 160);
				if (len > count - sent) len = count - sent;
				case ($urandom_range(0, 6))
					0, 1:    goal = 8'd255;
					2, 3:    goal = 8'd0;
					4:       goal = 8'(UNITY);
					default: goal = 8'($urandom_range(0, 255));
				endcase
				for (int i = 0; i < len; i++) begin
					feed_tick(goal);
				end
			end else begin
				len = $urandom_range(1, 20);
				if (len > count - sent) len = count - sent;
				for (int i = 0; i < len; i++) begin
					feed_tick(8'($urandom_range(0, 255)));
				end
			end
			sent += len;
		end
	endtask

	// -----------------------------------------------------------------------
	// Test sequence
	// -----------------------------------------------------------------------
	logic [7:0] directed_targets [14] = '{
		8'd127,   // target equals tracked: held, no change
		8'd128,   // one step up
		8'd128,   // now equal again
		8'd255,   // top of field
		8'd0,     // bottom of field, reverse
		8'd0,
		8'd126,
		8'd127,
		8'd255,
		8'd255,
		8'd0,
		8'd1,
		8'd254,
		8'd127
	};
	logic [15:0] phase_scales [6];

	initial begin
		phase_scales = '{16'hFFFF, 16'h0000, 16'h0001,
		                 16'($urandom_range(0, 65535)),
		                 16'($urandom_range(0, 4095)), SCALE_DEFAULT};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed ticks at the reset scale, back to back
		foreach (directed_targets[i]) begin
			send_tick(directed_targets[i]);
		end
		drain();

		// biggest scale: a short run both ways hits saturation and underflow
		write_scale(16'hFFFF);
		for (int i = 0; i < 6; i++) send_tick(8'd255);
		for (int i = 0; i < 12; i++) send_tick(8'd0);
		drain();

		// first random phase runs on the scale left from above
		random_phase(PHASE_TICKS);
		foreach (phase_scales[p]) begin
			drain();
			write_scale(phase_scales[p]);
			random_phase(PHASE_TICKS);
		end

		drain();
		repeat (30) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
